// ===== hw/rtl/psl_pkg.sv =====
`timescale 1ns / 1ps

package psl_pkg;

	// lamp bit positions
	localparam int unsigned LampCarRed    = 0;
	localparam int unsigned LampCarYellow = 1;
	localparam int unsigned LampCarGreen  = 2;
	localparam int unsigned LampWalkRed   = 3;
	localparam int unsigned LampWalkGreen = 4;
	localparam int unsigned LampWait      = 5;

	localparam logic [5:0] L_CRED = 6'b000001;
	localparam logic [5:0] L_CYEL = 6'b000010;
	localparam logic [5:0] L_CGRN = 6'b000100;
	localparam logic [5:0] L_WRED = 6'b001000;
	localparam logic [5:0] L_WGRN = 6'b010000;
	localparam logic [5:0] L_WAIT = 6'b100000;

	localparam logic [2:0] COUNT_STEPS = 3'd5;
	localparam logic [3:0] COUNT_TOP   = 4'd8;
	localparam logic [3:0] YEL_DIGIT   = 4'd3;
	localparam logic [2:0] RED_STEPS   = 3'd2;
	localparam logic [2:0] WALK_STEPS  = 3'd5;

	localparam logic [7:0] TICKS_PER_STEP_RESET = 8'd62;

	typedef enum logic [3:0] {
		PH_RED     = 4'd0,
		PH_RED_YEL = 4'd1,
		PH_GREEN   = 4'd2,
		PH_COUNT   = 4'd3,
		PH_YELLOW  = 4'd4,
		PH_RED_CNT = 4'd5,
		PH_WALK    = 4'd6
	} phase_t;

	typedef struct packed {
		logic timer_tick;
		logic request_press;
		logic fault_held;
	} item_t;

	typedef struct packed {
		logic [5:0] lamps;
		logic [3:0] digit_value;
		logic       digit_on;
		logic       in_fault;
	} result_t;

	typedef struct packed {
		phase_t     phase;
		logic [7:0] tick_count;
		logic [2:0] repeat_count;
		logic       request;
		logic [5:0] lamps;
		logic       fault;
	} seq_state_t;

	localparam seq_state_t SEQ_STATE_RESET = '{
		phase:        PH_RED,
		tick_count:   8'd0,
		repeat_count: 3'd0,
		request:      1'b0,
		lamps:        L_CRED | L_WRED,
		fault:        1'b0
	};

endpackage

// ===== hw/rtl/pedestrian_light_sequencer.sv =====
`timescale 1ns / 1ps

// pedestrian crossing light sequencer: each word on the item channel is one clock
// sample (timer tick, request press, fault level) and yields exactly one result word
// with the lamps, the countdown digit and the fault flag as they stand after that
// sample. the block takes one word per cycle while the result channel does not stall;
// an accepted word waits in the input register, then the sequencer update writes state
// and result together into the result register. a stalled result channel holds one
// word in the result register and one in the input register, after which item_ready
// drops. ticks_per_step is written over the cfg channel, which is always ready; write
// it only while no word is in flight. a step lasts ticks_per_step timer ticks (0 acts
// as 1); a held fault blanks everything and blinks car yellow per tick.

module pedestrian_light_sequencer (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              item_valid,
	output logic              item_ready,
	input  psl_pkg::item_t    item,
	output logic              result_valid,
	input  logic              result_ready,
	output psl_pkg::result_t  result,
	input  logic              cfg_valid,
	output logic              cfg_ready,
	input  logic [7:0]        cfg_data
);
	import psl_pkg::*;

	// configuration
	logic [7:0] ticks_per_step_q;

	// input register
	item_t      item_s1;
	logic       valid_s1;

	// sequencer state and result register
	seq_state_t state_q;
	seq_state_t state_nxt;
	result_t    result_nxt;
	result_t    result_q;
	logic       result_valid_q;

	logic       advance;

	// the s1 word moves on when the result register is empty or being drained
	assign advance    = valid_s1 && (!result_valid_q || result_ready);
	assign item_ready = !valid_s1 || advance;
	assign cfg_ready  = 1'b1;

	assign result_valid = result_valid_q;
	assign result       = result_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ticks_per_step_q <= TICKS_PER_STEP_RESET;
		end else if (cfg_valid) begin
			ticks_per_step_q <= cfg_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (item_ready) begin
			valid_s1 <= item_valid;
		end
	end

	// payload needs no reset
	always_ff @(posedge clk) begin
		if (item_ready && item_valid) begin
			item_s1 <= item;
		end
	end

	psl_step u_step (
		.item           (item_s1),
		.ticks_per_step (ticks_per_step_q),
		.cur            (state_q),
		.nxt            (state_nxt),
		.result         (result_nxt)
	);

	// state commits only when the sample is actually consumed
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= SEQ_STATE_RESET;
			result_valid_q <= 1'b0;
		end else begin
			if (advance) begin
				state_q <= state_nxt;
				result_valid_q <= 1'b1;
			end else if (result_ready) begin
				result_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			result_q <= result_nxt;
		end
	end

	// fault mode shows no digit and at most the blinking car yellow
	assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && result.in_fault |->
			!result.digit_on && ((result.lamps & ~L_CYEL) == 6'd0))
		else $error("fault result shows more than car yellow");

	// car green and walk green never light together
	assert property (@(posedge clk) disable iff (!arst_n)
		result_valid |-> !(result.lamps[LampCarGreen] && result.lamps[LampWalkGreen]))
		else $error("car green and walk green both lit");

	// a lit display always shows a countdown digit between 1 and 8
	assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && result.digit_on |->
			result.digit_value >= 4'd1 && result.digit_value <= COUNT_TOP && !result.in_fault)
		else $error("display digit out of range");

	// the input side stalls only when both registers are full and the output is held
	assert property (@(posedge clk) disable iff (!arst_n)
		!item_ready |-> valid_s1 && result_valid_q && !result_ready)
		else $error("item channel stalled without backpressure");

	// a stalled result word holds until taken
	assert property (@(posedge clk) disable iff (!arst_n)
		result_valid_q && !result_ready |=> result_valid_q && $stable(result_q))
		else $error("result word changed while stalled");

endmodule

// ===== hw/rtl/psl_step.sv =====
`timescale 1ns / 1ps

module psl_step (
	input  psl_pkg::item_t      item,
	input  logic [7:0]          ticks_per_step,
	input  psl_pkg::seq_state_t cur,
	output psl_pkg::seq_state_t nxt,
	output psl_pkg::result_t    result
);
	import psl_pkg::*;

	logic [7:0] tick_inc;
	logic [2:0] rep_inc;
	logic [5:0] wait_lamp;

	always_comb begin
		nxt = cur;
		result = '0;
		tick_inc = 8'd0;
		rep_inc = 3'd0;
		wait_lamp = 6'd0;

		if (item.fault_held) begin
			if (!cur.fault) begin
				nxt.fault = 1'b1;
				nxt.lamps = 6'd0;
				nxt.request = 1'b0;
				nxt.phase = PH_RED;
				nxt.tick_count = 8'd0;
				nxt.repeat_count = 3'd0;
			end
			if (item.timer_tick) begin
				nxt.lamps = nxt.lamps ^ L_CYEL;
			end
		end else if (cur.fault) begin
			nxt = SEQ_STATE_RESET;
		end else begin
			// out-of-range phase code restarts the car phase
			if (cur.phase > PH_WALK) begin
				nxt.phase = PH_RED;
				nxt.repeat_count = 3'd0;
				nxt.tick_count = 8'd0;
			end
			if (item.request_press && nxt.phase <= PH_GREEN) begin
				nxt.request = 1'b1;
			end
			tick_inc = nxt.tick_count + 8'd1;
			rep_inc = nxt.repeat_count + 3'd1;
			if (nxt.phase == PH_GREEN) begin
				nxt.tick_count = 8'd0;
				if (nxt.request) begin
					nxt.phase = PH_COUNT;
					nxt.repeat_count = 3'd0;
				end
			end else if (item.timer_tick) begin
				nxt.tick_count = tick_inc;
				if (tick_inc >= ticks_per_step) begin
					nxt.tick_count = 8'd0;
					case (nxt.phase)
						PH_RED: begin
							nxt.phase = PH_RED_YEL;
						end
						PH_RED_YEL: begin
							nxt.phase = PH_GREEN;
						end
						PH_COUNT: begin
							nxt.repeat_count = rep_inc;
							if (rep_inc >= COUNT_STEPS) begin
								nxt.phase = PH_YELLOW;
								nxt.repeat_count = 3'd0;
							end
						end
						PH_YELLOW: begin
							nxt.phase = PH_RED_CNT;
							nxt.repeat_count = 3'd0;
						end
						PH_RED_CNT: begin
							nxt.repeat_count = rep_inc;
							if (rep_inc >= RED_STEPS) begin
								nxt.phase = PH_WALK;
								nxt.repeat_count = 3'd0;
							end
						end
						default: begin
							nxt.repeat_count = rep_inc;
							if (rep_inc >= WALK_STEPS) begin
								nxt.phase = PH_RED;
								nxt.repeat_count = 3'd0;
								nxt.request = 1'b0;
							end
						end
					endcase
				end
			end

			wait_lamp = nxt.request ? L_WAIT : 6'd0;
			case (nxt.phase)
				PH_RED:     nxt.lamps = L_CRED | L_WRED | wait_lamp;
				PH_RED_YEL: nxt.lamps = L_CRED | L_CYEL | L_WRED | wait_lamp;
				PH_GREEN:   nxt.lamps = L_CGRN | L_WRED | wait_lamp;
				PH_COUNT:   nxt.lamps = L_CGRN | L_WRED | L_WAIT;
				PH_YELLOW:  nxt.lamps = L_CYEL | L_WRED | L_WAIT;
				PH_RED_CNT: nxt.lamps = L_CRED | L_WRED | L_WAIT;
				default:    nxt.lamps = L_CRED | L_WGRN;
			endcase

			case (nxt.phase)
				PH_COUNT: begin
					result.digit_value = COUNT_TOP - {1'b0, nxt.repeat_count};
					result.digit_on = 1'b1;
				end
				PH_YELLOW: begin
					result.digit_value = YEL_DIGIT;
					result.digit_on = 1'b1;
				end
				PH_RED_CNT: begin
					result.digit_value = {1'b0, RED_STEPS - nxt.repeat_count};
					result.digit_on = 1'b1;
				end
				default: begin
					result.digit_value = 4'd0;
					result.digit_on = 1'b0;
				end
			endcase
		end

		result.lamps = nxt.lamps;
		result.in_fault = nxt.fault;
	end

endmodule

// ===== test/tb.sv =====
`timescale 1ns / 1ps

module tb;
	import psl_pkg::*;

	localparam int CYCLE_LIMIT = 400000;
	localparam int SETTLE_CYCLES = 6;   // two-stage pipe plus margin
	localparam int REPORT_MAX = 10;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        item_valid = 1'b0;
	logic        item_ready;
	item_t       item = '0;
	logic        result_valid;
	logic        result_ready = 1'b0;
	result_t     result;
	logic        cfg_valid = 1'b0;
	logic        cfg_ready;
	logic [7:0]  cfg_data = '0;

	pedestrian_light_sequencer uut (
		.clk          (clk),
		.arst_n       (arst_n),
		.item_valid   (item_valid),
		.item_ready   (item_ready),
		.item         (item),
		.result_valid (result_valid),
		.result_ready (result_ready),
		.result       (result),
		.cfg_valid    (cfg_valid),
		.cfg_ready    (cfg_ready),
		.cfg_data     (cfg_data)
	);

	// samples waiting to be driven, predicted light words waiting to come out
	item_t       sample_queue[$];
	result_t     light_queue[$];

	// predicted sequencer state and its copy of the step length register
	seq_state_t  lights = SEQ_STATE_RESET;
	logic [7:0]  step_ticks = TICKS_PER_STEP_RESET;

	int          fail_count = 0;
	int          cycle_count = 0;
	logic        item_taken = 1'b0;

	// sender burst state and receiver stall pattern
	int          burst_left = 0;
	int          gap_left = 0;
	logic [31:0] stall_bits = '1;
	int          stall_idx = 0;

	initial begin
		forever #10 clk = ~clk;
	end

	// one clock sample through the sequencer: updates lights, returns the word shown
	task automatic advance_lights(input item_t s, output result_t r);
		r = '0;
		if (s.fault_held) begin
			// fault entry drops the phase at once and blanks everything
			if (!lights.fault) begin
				lights.fault        = 1'b1;
				lights.lamps        = '0;
				lights.request      = 1'b0;
				lights.phase        = PH_RED;
				lights.tick_count   = '0;
				lights.repeat_count = '0;
			end
			// car yellow blinks on each tick, even in the entry sample
			if (s.timer_tick)
				lights.lamps = lights.lamps ^ L_CYEL;
		end else if (lights.fault) begin
			// release sample only restarts, its tick and press are dropped
			lights = SEQ_STATE_RESET;
		end else begin
			if (lights.phase > PH_WALK) begin
				lights.phase        = PH_RED;
				lights.repeat_count = '0;
				lights.tick_count   = '0;
			end
			// press is latched before the tick is looked at
			if (s.request_press && lights.phase <= PH_GREEN)
				lights.request = 1'b1;
			if (lights.phase == PH_GREEN) begin
				// green holds with no tick counting until a request is latched
				lights.tick_count = '0;
				if (lights.request) begin
					lights.phase        = PH_COUNT;
					lights.repeat_count = '0;
				end
			end else if (s.timer_tick) begin
				lights.tick_count = lights.tick_count + 8'd1;
				// a step length of zero behaves as one
				if (lights.tick_count >= step_ticks) begin
					lights.tick_count = '0;
					case (lights.phase)
						PH_RED: begin
							lights.phase = PH_RED_YEL;
						end
						PH_RED_YEL: begin
							lights.phase = PH_GREEN;
						end
						PH_COUNT: begin
							lights.repeat_count = lights.repeat_count + 3'd1;
							if (lights.repeat_count >= COUNT_STEPS) begin
								lights.phase        = PH_YELLOW;
								lights.repeat_count = '0;
							end
						end
						PH_YELLOW: begin
							lights.phase        = PH_RED_CNT;
							lights.repeat_count = '0;
						end
						PH_RED_CNT: begin
							lights.repeat_count = lights.repeat_count + 3'd1;
							if (lights.repeat_count >= RED_STEPS) begin
								lights.phase        = PH_WALK;
								lights.repeat_count = '0;
							end
						end
						default: begin
							lights.repeat_count = lights.repeat_count + 3'd1;
							if (lights.repeat_count >= WALK_STEPS) begin
								lights.phase        = PH_RED;
								lights.repeat_count = '0;
								lights.request      = 1'b0;
							end
						end
					endcase
				end
			end
			// lamps follow the phase; the wait lamp stays lit through the countdown
			case (lights.phase)
				PH_RED:     lights.lamps = L_CRED | L_WRED | (lights.request ? L_WAIT : 6'd0);
				PH_RED_YEL: lights.lamps = L_CRED | L_CYEL | L_WRED |
				                           (lights.request ? L_WAIT : 6'd0);
				PH_GREEN:   lights.lamps = L_CGRN | L_WRED | (lights.request ? L_WAIT : 6'd0);
				PH_COUNT:   lights.lamps = L_CGRN | L_WRED | L_WAIT;
				PH_YELLOW:  lights.lamps = L_CYEL | L_WRED | L_WAIT;
				PH_RED_CNT: lights.lamps = L_CRED | L_WRED | L_WAIT;
				default:    lights.lamps = L_CRED | L_WGRN;
			endcase
			// display counts 8..4, then 3 on yellow, then 2 and 1 on red
			if (lights.phase == PH_COUNT) begin
				r.digit_value = COUNT_TOP - {1'b0, lights.repeat_count};
				r.digit_on    = 1'b1;
			end else if (lights.phase == PH_YELLOW) begin
				r.digit_value = YEL_DIGIT;
				r.digit_on    = 1'b1;
			end else if (lights.phase == PH_RED_CNT) begin
				r.digit_value = {1'b0, RED_STEPS} - {1'b0, lights.repeat_count};
				r.digit_on    = 1'b1;
			end
		end
		r.lamps    = lights.lamps;
		r.in_fault = lights.fault;
	endtask

	task automatic push_sample(input logic tick, input logic press, input logic fault);
		item_t s;
		s.timer_tick    = tick;
		s.request_press = press;
		s.fault_held    = fault;
		sample_queue.push_back(s);
	endtask

	// random samples; faults come as held bursts of a few samples
	task automatic queue_random(input int n, input int tick_pct, input int press_pct,
	                            input int fault_pct);
		int fault_left;
		fault_left = 0;
		for (int k = 0; k < n; k++) begin
			if (fault_left == 0 && $urandom_range(99) < fault_pct)
				fault_left = $urandom_range(1, 6);
			push_sample($urandom_range(99) < tick_pct, $urandom_range(99) < press_pct,
			            fault_left != 0);
			if (fault_left != 0)
				fault_left--;
		end
	endtask

	// block goes idle: everything driven, every predicted word seen, pipe drained
	task automatic wait_idle();
		while (sample_queue.size() != 0 || item_valid || light_queue.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_step_ticks(input logic [7:0] v);
		@(negedge clk);
		cfg_valid <= 1'b1;
		cfg_data  <= v;
		@(posedge clk);
		while (!cfg_ready)
			@(posedge clk);
		step_ticks = v;
		@(negedge clk);
		cfg_valid <= 1'b0;
	endtask

	// sender: new word only after the last one was taken, bursts with random gaps
	always @(negedge clk) begin
		if (!arst_n) begin
			item_valid <= 1'b0;
		end else if (!item_valid || item_taken) begin
			if (gap_left != 0) begin
				item_valid <= 1'b0;
				gap_left = gap_left - 1;
			end else if (sample_queue.size() != 0) begin
				item_valid <= 1'b1;
				item       <= sample_queue.pop_front();
				if (burst_left <= 1) begin
					burst_left = $urandom_range(1, 16);
					// half the bursts run back to back
					gap_left   = $urandom_range(1) ? 0 : $urandom_range(1, 5);
				end else begin
					burst_left = burst_left - 1;
				end
			end else begin
				item_valid <= 1'b0;
			end
		end
	end

	// receiver: stall pattern reloaded after each pass through its 32 bits, from always ready to mostly stalled
	always @(negedge clk) begin
		result_ready <= stall_bits[stall_idx];
		if (stall_idx == 31) begin
			stall_idx = 0;
			case ($urandom_range(3))
				0:       stall_bits = '1;
				1:       stall_bits = $urandom;
				2:       stall_bits = $urandom | $urandom;
				default: stall_bits = $urandom & $urandom;
			endcase
		end else begin
			stall_idx = stall_idx + 1;
		end
	end

	// monitor: predict on each accepted sample, check each accepted light word
	always @(posedge clk) begin
		result_t want;
		item_t   seen;
		cycle_count = cycle_count + 1;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("** pedestrian_light_sequencer: FAILED **");
			$finish;
		end else begin
			item_taken <= arst_n && item_valid && item_ready;
			if (arst_n && item_valid && item_ready) begin
				seen = item;
				advance_lights(seen, want);
				light_queue.push_back(want);
			end
			if (arst_n && result_valid && result_ready) begin
				if (light_queue.size() == 0) begin
					fail_count = fail_count + 1;
					if (fail_count <= REPORT_MAX)
						$display("unexpected word: lamps %b digit %0d on %b fault %b",
						         result.lamps, result.digit_value, result.digit_on,
						         result.in_fault);
				end else begin
					want = light_queue.pop_front();
					if (result.lamps !== want.lamps || result.digit_value !== want.digit_value ||
					    result.digit_on !== want.digit_on || result.in_fault !== want.in_fault)
					begin
						fail_count = fail_count + 1;
						if (fail_count <= REPORT_MAX)
							$display({"mismatch at cycle %0d: lamps %b/%b digit %0d/%0d ",
							          "on %b/%b fault %b/%b (expected/actual)"},
							         cycle_count, want.lamps, result.lamps, want.digit_value,
							         result.digit_value, want.digit_on, result.digit_on,
							         want.in_fault, result.in_fault);
					end
				end
			end
		end
	end

	initial begin
		int tick_pct;
		repeat (8) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// reset step length: a long tick run crosses the first step end
		queue_random(70, 97, 3, 0);
		wait_idle();

		// one tick per step: a full walk cycle, then fault entry, hold and release
		write_step_ticks(8'd1);
		push_sample(0, 0, 0);
		push_sample(1, 0, 0);
		push_sample(0, 1, 0);                   // latch while red-yellow
		push_sample(1, 0, 0);                   // green entered with request pending
		push_sample(0, 0, 0);
		repeat (5) push_sample(1, 1, 0);        // presses ignored in the countdown
		push_sample(1, 0, 0);
		push_sample(1, 0, 0);
		push_sample(1, 1, 0);
		repeat (5) push_sample(1, 0, 0);        // walk green, then back to car red
		push_sample(1, 1, 0);                   // press and tick together
		push_sample(1, 0, 1);                   // fault entry with a tick
		push_sample(1, 1, 1);
		push_sample(0, 1, 1);
		push_sample(1, 1, 0);                   // release drops tick and press
		push_sample(0, 0, 0);
		wait_idle();

		// zero step length behaves as one
		write_step_ticks(8'd0);
		queue_random(40, 70, 10, 4);
		wait_idle();

		// long step: one boundary crossing at full tick rate
		write_step_ticks(8'd140);
		queue_random(150, 100, 2, 0);
		wait_idle();

		// random short steps, well-formed runs with some fault bursts
		repeat (4) begin
			write_step_ticks(8'($urandom_range(3) == 0 ? $urandom_range(5, 12) :
			                                             $urandom_range(1, 4)));
			tick_pct = $urandom_range(50, 95);
			queue_random(30, tick_pct, 8, 3);
			wait_idle();
		end

		if (fail_count == 0 && light_queue.size() == 0)
			$display("** pedestrian_light_sequencer: PASSED **");
		else
			$display("** pedestrian_light_sequencer: FAILED **");
		$finish;
	end

endmodule
